// ===== design/assert_macros.svh =====
// Assertion macros shared by the fast exp2 design files.
// No dependencies; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define FEXP2_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define FEXP2_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== design/fexp2_pkg.sv =====
// Shared constants and types for the fast exp2 approximation pipeline.
// No dependencies.
package fexp2_pkg;

   // fixed-point formats
   localparam int IN_W           = 24;
   localparam int IN_FRAC_BITS   = 16;
   localparam int INT_W          = IN_W - IN_FRAC_BITS;
   localparam int COEF_W         = 24;
   localparam int COEF_FRAC_BITS = 24;
   localparam int MAX_CF         = (COEF_W > COEF_FRAC_BITS) ? COEF_W : COEF_FRAC_BITS;
   localparam int T_W            = MAX_CF + 2;   // Horner accumulator, holds m < 2^(T_W)
   localparam int MANT_BITS      = 23;
   localparam int EXP_BITS       = 8;
   localparam int OUT_W          = EXP_BITS + MANT_BITS;
   localparam int E_W            = ((INT_W > EXP_BITS) ? INT_W : EXP_BITS) + 2;
   localparam int EXP_BIAS       = 127;
   localparam int EXP_MAX        = 254;
   localparam logic [OUT_W-1:0] MAX_FINITE = 31'h7F7FFFFF;

   // mantissa 1.0 and 2.0 in accumulator format
   localparam logic [T_W-1:0] T_ONE = T_W'(1) << COEF_FRAC_BITS;
   localparam logic [T_W-1:0] T_TWO = T_W'(2) << COEF_FRAC_BITS;

   // register file
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_LINEAR = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SQUARE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CUBE   = 2'd2;

   localparam logic [COEF_W-1:0] LINEAR_RST = 24'd11678044;
   localparam logic [COEF_W-1:0] SQUARE_RST = 24'd3766390;
   localparam logic [COEF_W-1:0] CUBE_RST   = 24'd1332786;

   typedef struct packed {
      logic [COEF_W-1:0] linear;
      logic [COEF_W-1:0] square;
      logic [COEF_W-1:0] cube;
   } coef_type;

   // word carried down the pipe
   typedef struct packed {
      logic [COEF_FRAC_BITS-1:0] d;   // fraction, Q0.COEF_FRAC_BITS
      logic signed [INT_W-1:0]   n;   // floor integer part
      logic [T_W-1:0]            t;   // Horner partial
   } stage_type;

endpackage

// ===== design/fexp2_csr.sv =====
// Coefficient registers for the fast exp2 approximation.
// Depends on fexp2_pkg.
module fexp2_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_en,
   input  logic [fexp2_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [fexp2_pkg::COEF_W-1:0]       csr_data,
   output fexp2_pkg::coef_type                coef
);

   fexp2_pkg::coef_type coef_ff, coef_in;

   always_comb begin
      coef_in = coef_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            fexp2_pkg::CSR_LINEAR: coef_in.linear = csr_data;
            fexp2_pkg::CSR_SQUARE: coef_in.square = csr_data;
            fexp2_pkg::CSR_CUBE:   coef_in.cube   = csr_data;
            default:               coef_in = coef_ff;   // unmapped index ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff.linear <= fexp2_pkg::LINEAR_RST;
         coef_ff.square <= fexp2_pkg::SQUARE_RST;
         coef_ff.cube   <= fexp2_pkg::CUBE_RST;
      end else begin
         coef_ff <= coef_in;
      end
   end

   assign coef = coef_ff;

endmodule

// ===== design/fexp2_horner.sv =====
// One registered Horner step: t' = c + floor(d * t / 2^COEF_FRAC_BITS).
// Depends on fexp2_pkg.
module fexp2_horner (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  fexp2_pkg::stage_type          in_word,
   input  logic [fexp2_pkg::T_W-1:0]     coef,
   output logic                          out_valid,
   output fexp2_pkg::stage_type          out_word
);

   localparam int P_W = fexp2_pkg::COEF_FRAC_BITS + fexp2_pkg::T_W;

   logic [P_W-1:0]           prod;
   logic                     valid_ff;
   fexp2_pkg::stage_type     word_ff, word_in;

   always_comb begin
      prod       = P_W'(in_word.d) * P_W'(in_word.t);
      word_in    = in_word;
      word_in.t  = coef + prod[P_W-1:fexp2_pkg::COEF_FRAC_BITS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

// ===== design/fexp2_pack.sv =====
// Mantissa saturation, exponent bias and range checks, float packing.
// Depends on fexp2_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fexp2_pack (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  fexp2_pkg::stage_type            in_word,
   output logic                            rsp_valid,
   output logic [fexp2_pkg::OUT_W-1:0]     rsp_power_bits,
   output logic                            rsp_flushed_to_zero
);

   localparam int CF = fexp2_pkg::COEF_FRAC_BITS;
   localparam int MB = fexp2_pkg::MANT_BITS;
   localparam int EW = fexp2_pkg::E_W;

   logic [CF-1:0]                 m_frac;
   logic [CF+MB-1:0]              m_wide;
   logic [MB-1:0]                 mant;
   logic signed [EW-1:0]          e;
   logic                          flush;
   logic                          ovf;
   logic                          valid_ff;
   logic [fexp2_pkg::OUT_W-1:0]   bits_ff, bits_in;
   logic                          flush_ff;

   always_comb begin
      // m is in [1, 2+): clamp just below 2
      if (in_word.t >= fexp2_pkg::T_TWO) begin
         m_frac = '1;
      end else begin
         m_frac = in_word.t[CF-1:0];
      end
      m_wide = {m_frac, {MB{1'b0}}};
      mant   = m_wide[CF+MB-1:CF];

      e     = EW'(fexp2_pkg::EXP_BIAS) + EW'(in_word.n);
      flush = (e < EW'(1));
      ovf   = (e > EW'(fexp2_pkg::EXP_MAX));

      if (flush) begin
         bits_in = '0;
      end else if (ovf) begin
         bits_in = fexp2_pkg::MAX_FINITE;
      end else begin
         bits_in = {e[fexp2_pkg::EXP_BITS-1:0], mant};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      bits_ff  <= bits_in;
      flush_ff <= flush;
   end

   assign rsp_valid           = valid_ff;
   assign rsp_power_bits      = bits_ff;
   assign rsp_flushed_to_zero = flush_ff;

   // a flushed word carries an all-zero pattern
   `FEXP2_ASSERT_IMP(a_flush_zero, clock, reset, rsp_valid && rsp_flushed_to_zero,
                     rsp_power_bits == '0)
   // never an inf/NaN exponent field
   `FEXP2_ASSERT_IMP(a_finite, clock, reset, rsp_valid,
                     rsp_power_bits[fexp2_pkg::OUT_W-1:MB] != '1)

endmodule

// ===== design/fast_exp2_approx.sv =====
// Top level of the fast exp2 approximation: 2^x from Q8.16 to float32 bits, no sign bit.
// Depends on fexp2_pkg, fexp2_csr, fexp2_horner, fexp2_pack, assert_macros.svh.
//
//   channel   ports                                 handshake
//   -------   -----------------------------------   --------------------------
//   request   req_exponent_in                       start & !busy
//   response  rsp_power_bits, rsp_flushed_to_zero   rsp_valid, one-cycle strobe
//   csr       csr_index, csr_data                   csr_write_en, no wait
//
// A word is taken every cycle while busy is low; each result strobes out of the pack register.
// Stages: input split, three Horner multiply-add steps, pack/output register.
// The 24 x 26 multiply in each Horner step sets the cycle time.
// busy is high only while reset is held; synchronous reset clears valid bits
// and loads the coefficient defaults. The receiver cannot stall, so nothing
// ever backs up in the pipe.
`include "assert_macros.svh"

module fast_exp2_approx (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [fexp2_pkg::IN_W-1:0]   req_exponent_in,
   output logic                                rsp_valid,
   output logic [fexp2_pkg::OUT_W-1:0]         rsp_power_bits,
   output logic                                rsp_flushed_to_zero,
   input  logic                                csr_write_en,
   input  logic [fexp2_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [fexp2_pkg::COEF_W-1:0]        csr_data
);

   localparam int IF  = fexp2_pkg::IN_FRAC_BITS;
   localparam int CF  = fexp2_pkg::COEF_FRAC_BITS;
   localparam int TW  = fexp2_pkg::T_W;

   fexp2_pkg::coef_type   coef;
   logic                  accept;

   // input split stage
   logic [IF+CF-1:0]      frac_wide;
   logic                  s0_valid_ff;
   fexp2_pkg::stage_type  s0_ff, s0_in;

   // Horner chain
   logic                  s1_valid, s2_valid, s3_valid;
   fexp2_pkg::stage_type  s1_word, s2_word, s3_word;

   assign busy   = reset;
   assign accept = start && !busy;

   fexp2_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .coef         (coef)
   );

   // floor split: low bits are the fraction, the arithmetic top is n.
   // The fraction is rescaled to the coefficient format (zero-padded, exact).
   always_comb begin
      frac_wide = {req_exponent_in[IF-1:0], {CF{1'b0}}};
      s0_in.d   = frac_wide[IF+CF-1:IF];
      s0_in.n   = req_exponent_in[fexp2_pkg::IN_W-1:IF];
      s0_in.t   = TW'(coef.cube);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      s0_ff <= s0_in;
   end

   // t1 = c2 + d*c3
   fexp2_horner u_h1 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s0_valid_ff),
      .in_word   (s0_ff),
      .coef      (TW'(coef.square)),
      .out_valid (s1_valid),
      .out_word  (s1_word)
   );

   // t2 = c1 + d*t1
   fexp2_horner u_h2 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_word   (s1_word),
      .coef      (TW'(coef.linear)),
      .out_valid (s2_valid),
      .out_word  (s2_word)
   );

   // m = 1 + d*t2
   fexp2_horner u_h3 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_word   (s2_word),
      .coef      (fexp2_pkg::T_ONE),
      .out_valid (s3_valid),
      .out_word  (s3_word)
   );

   fexp2_pack u_pack (
      .clock               (clock),
      .reset               (reset),
      .in_valid            (s3_valid),
      .in_word             (s3_word),
      .rsp_valid           (rsp_valid),
      .rsp_power_bits      (rsp_power_bits),
      .rsp_flushed_to_zero (rsp_flushed_to_zero)
   );

   // every strobe traces back to an accepted word, through the split, Horner and pack registers
   `FEXP2_ASSERT_IMP(a_rsp_src, clock, reset, rsp_valid, $past(accept, 5))
   // the split stage picks up exactly the accepted words
   `FEXP2_ASSERT_NXT(a_s0_load, clock, reset, accept, s0_valid_ff)

endmodule

// ===== sim/fast_exp2_approx_tb.sv =====
// Self-checking testbench for fast_exp2_approx: 2^x from Q8.16 to float32 bits, no sign bit.
// Depends on fexp2_pkg and the fast_exp2_approx RTL; needs no files or arguments.
`timescale 1ns / 1ps

module fast_exp2_approx_tb;

   // index 3 decodes to no register; writes there must be dropped
   localparam logic [fexp2_pkg::CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam int STALL_LIMIT = 200;   // cycles with no handshake of any kind

   typedef struct packed {
      logic [fexp2_pkg::OUT_W-1:0] bits;
      logic                        flushed;
   } power_word_type;

   // shapes of random exponent words
   typedef enum int {
      SHAPE_UNIFORM,
      SHAPE_UNDERFLOW_EDGE,
      SHAPE_FRAC_EDGE,
      SHAPE_TOP_RANGE
   } exponent_shape_type;

   logic                                 clock;
   logic                                 reset;
   logic                                 start;
   logic                                 busy;
   logic signed [fexp2_pkg::IN_W-1:0]    req_exponent_in;
   logic                                 rsp_valid;
   logic [fexp2_pkg::OUT_W-1:0]          rsp_power_bits;
   logic                                 rsp_flushed_to_zero;
   logic                                 csr_write_en;
   logic [fexp2_pkg::CSR_IDX_W-1:0]      csr_index;
   logic [fexp2_pkg::COEF_W-1:0]         csr_data;

   // words waiting to be sent, and results owed by the block
   logic [fexp2_pkg::IN_W-1:0]           pending_exponents[$];
   power_word_type                       expected_powers[$];

   // local copy of the coefficient registers
   logic [fexp2_pkg::COEF_W-1:0]         model_linear;
   logic [fexp2_pkg::COEF_W-1:0]         model_square;
   logic [fexp2_pkg::COEF_W-1:0]         model_cube;

   logic                                 word_taken;
   logic                                 sender_bursts_on;
   int                                   gap_left;
   int                                   idle_cycles;
   int                                   mismatch_count;

   fast_exp2_approx u_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_exponent_in     (req_exponent_in),
      .rsp_valid           (rsp_valid),
      .rsp_power_bits      (rsp_power_bits),
      .rsp_flushed_to_zero (rsp_flushed_to_zero),
      .csr_write_en        (csr_write_en),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // 2^x prediction. Floor split: top bits are n, low bits the fraction d.
   // Horner in unsigned Q.24 with each product truncated, mantissa clamped
   // just below 2, then n added to the biased exponent.
   function automatic power_word_type exp2_predict(logic [fexp2_pkg::IN_W-1:0] x);
      logic signed [fexp2_pkg::INT_W-1:0] n_int;
      longint unsigned                    d;
      longint unsigned                    acc;
      longint unsigned                    unity;
      longint unsigned                    mant;
      int                                 biased;
      power_word_type                     w;
      n_int = x[fexp2_pkg::IN_W-1:fexp2_pkg::IN_FRAC_BITS];
      d     = longint'(x[fexp2_pkg::IN_FRAC_BITS-1:0])
              << (fexp2_pkg::COEF_FRAC_BITS - fexp2_pkg::IN_FRAC_BITS);
      unity = 64'd1 << fexp2_pkg::COEF_FRAC_BITS;
      acc   = model_cube;
      acc   = model_square + ((d * acc) >> fexp2_pkg::COEF_FRAC_BITS);
      acc   = model_linear + ((d * acc) >> fexp2_pkg::COEF_FRAC_BITS);
      acc   = unity + ((d * acc) >> fexp2_pkg::COEF_FRAC_BITS);
      if (acc >= 2 * unity) begin
         acc = 2 * unity - 1;
      end
      mant   = (acc - unity) >> (fexp2_pkg::COEF_FRAC_BITS - fexp2_pkg::MANT_BITS);
      biased = fexp2_pkg::EXP_BIAS + int'(n_int);
      if (biased < 1) begin
         // underflow, including biased 0: no denormals
         w.bits    = '0;
         w.flushed = 1'b1;
      end else if (biased > fexp2_pkg::EXP_MAX) begin
         w.bits    = fexp2_pkg::MAX_FINITE;
         w.flushed = 1'b0;
      end else begin
         w.bits    = {biased[fexp2_pkg::EXP_BITS-1:0], mant[fexp2_pkg::MANT_BITS-1:0]};
         w.flushed = 1'b0;
      end
      return w;
   endfunction

   // Random exponent: one shape in four uniform, the rest aimed at the flush boundary,
   // the fraction extremes and the top of the integer range.
   function automatic logic [fexp2_pkg::IN_W-1:0] pick_exponent();
      exponent_shape_type          shape;
      logic [fexp2_pkg::INT_W-1:0] n_bits;
      logic [15:0]                 f_bits;
      shape  = exponent_shape_type'($urandom_range(0, 3));
      n_bits = fexp2_pkg::INT_W'($urandom);
      f_bits = 16'($urandom);
      case (shape)
         SHAPE_UNDERFLOW_EDGE: begin
            n_bits = 8'h80 + 8'($urandom_range(0, 3));   // n = -128 .. -125
         end
         SHAPE_FRAC_EDGE: begin
            case ($urandom_range(0, 2))
               0: f_bits = 16'h0000;
               1: f_bits = 16'hFFFF;
               default: f_bits = 16'h8000;
            endcase
         end
         SHAPE_TOP_RANGE: begin
            n_bits = 8'h7F - 8'($urandom_range(0, 2));
         end
         default: begin
            return fexp2_pkg::IN_W'($urandom);
         end
      endcase
      return {n_bits, f_bits};
   endfunction

   // Driver: one word per cycle unless a random gap burst is running.
   // A word stays on the port until start & !busy has taken it.
   always @(negedge clock) begin : drive_proc
      if (reset) begin
         start    <= 1'b0;
         gap_left = 0;
      end else if (start && !word_taken) begin
         // hold the current word
      end else if (gap_left > 0) begin
         gap_left = gap_left - 1;
         start    <= 1'b0;
      end else if (sender_bursts_on && $urandom_range(0, 7) == 0) begin
         gap_left = $urandom_range(1, 11) - 1;
         start    <= 1'b0;
      end else if (pending_exponents.size() > 0) begin
         start           <= 1'b1;
         req_exponent_in <= pending_exponents.pop_front();
      end else begin
         start <= 1'b0;
      end
   end

   // Monitor: predicts on every accepted word, tracks register writes,
   // checks every response strobe against the oldest prediction.
   always @(posedge clock) begin : watch_proc
      power_word_type want;
      if (reset) begin
         word_taken   = 1'b0;
         idle_cycles  = 0;
         model_linear = fexp2_pkg::LINEAR_RST;
         model_square = fexp2_pkg::SQUARE_RST;
         model_cube   = fexp2_pkg::CUBE_RST;
      end else begin
         word_taken = start && !busy;
         if (word_taken) begin
            expected_powers.push_back(exp2_predict(req_exponent_in));
         end
         if (csr_write_en) begin
            case (csr_index)
               fexp2_pkg::CSR_LINEAR: model_linear = csr_data;
               fexp2_pkg::CSR_SQUARE: model_square = csr_data;
               fexp2_pkg::CSR_CUBE:   model_cube   = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid) begin
            if (expected_powers.size() == 0) begin
               $display("%0t unexpected word: expected none actual power_bits %h flushed %b",
                        $time, rsp_power_bits, rsp_flushed_to_zero);
               mismatch_count++;
            end else begin
               want = expected_powers.pop_front();
               if (rsp_power_bits !== want.bits) begin
                  $display("%0t power_bits expected %h actual %h", $time,
                           want.bits, rsp_power_bits);
                  mismatch_count++;
               end
               if (rsp_flushed_to_zero !== want.flushed) begin
                  $display("%0t flushed_to_zero expected %b actual %b", $time,
                           want.flushed, rsp_flushed_to_zero);
                  mismatch_count++;
               end
            end
         end
         if (word_taken || rsp_valid || csr_write_en) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
   end

   // Watchdog: nothing moved on any port for too long.
   initial begin : watchdog_proc
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   task automatic write_coef(input logic [fexp2_pkg::CSR_IDX_W-1:0] idx,
                             input logic [fexp2_pkg::COEF_W-1:0] val);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_data     <= val;
   endtask

   task automatic end_writes();
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Sender idle and every owed word back; the pipe holds nothing then.
   task automatic wait_drained();
      do begin
         @(posedge clock);
      end while (pending_exponents.size() != 0 || start || expected_powers.size() != 0);
      repeat (2) @(posedge clock);
   endtask

   task automatic queue_random(input int count);
      for (int k = 0; k < count; k++) begin
         pending_exponents.push_back(pick_exponent());
      end
   endtask

   initial begin : stimulus_proc
      idle_cycles      = 0;
      mismatch_count   = 0;
      gap_left         = 0;
      word_taken       = 1'b0;
      sender_bursts_on = 1'b1;
      reset            = 1'b1;
      start            = 1'b0;
      req_exponent_in  = '0;
      csr_write_en     = 1'b0;
      csr_index        = fexp2_pkg::CSR_LINEAR;
      csr_data         = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset coefficients: zero, ends of the range, flush boundary,
      // largest exponent, fraction extremes
      pending_exponents.push_back(24'h000000);
      pending_exponents.push_back(24'h7FFFFF);   // most positive
      pending_exponents.push_back(24'h800000);   // most negative, flushed
      pending_exponents.push_back(24'hFFFFFF);   // just below zero
      pending_exponents.push_back(24'h000001);
      pending_exponents.push_back(24'h00FFFF);
      pending_exponents.push_back(24'h010000);
      pending_exponents.push_back(24'h008000);
      pending_exponents.push_back(24'hFF0000);   // -1.0
      pending_exponents.push_back(24'h820000);   // n = -126, smallest normal
      pending_exponents.push_back(24'h82FFFF);
      pending_exponents.push_back(24'h81FFFF);   // n = -127, flushed
      pending_exponents.push_back(24'h810000);
      pending_exponents.push_back(24'h7F0000);   // n = 127, top exponent
      pending_exponents.push_back(24'h123456);
      pending_exponents.push_back(24'hAAAAAA);
      pending_exponents.push_back(24'h555555);
      wait_drained();

      // all coefficients at full scale: mantissa clamps below 2;
      // the spare index must not disturb anything
      write_coef(fexp2_pkg::CSR_LINEAR, 24'hFFFFFF);
      write_coef(fexp2_pkg::CSR_SQUARE, 24'hFFFFFF);
      write_coef(fexp2_pkg::CSR_CUBE, 24'hFFFFFF);
      write_coef(CSR_SPARE, fexp2_pkg::COEF_W'($urandom));
      end_writes();
      pending_exponents.push_back(24'h00FFFF);
      pending_exponents.push_back(24'h7FFFFF);
      pending_exponents.push_back(24'h00C000);
      pending_exponents.push_back(24'h000001);
      pending_exponents.push_back(24'h82FFFF);
      queue_random(60);
      wait_drained();

      // all zero: mantissa is exactly 1
      write_coef(fexp2_pkg::CSR_LINEAR, 24'h000000);
      write_coef(fexp2_pkg::CSR_SQUARE, 24'h000000);
      write_coef(fexp2_pkg::CSR_CUBE, 24'h000000);
      end_writes();
      queue_random(60);
      wait_drained();

      // random coefficients, with a full drain pause halfway
      write_coef(fexp2_pkg::CSR_CUBE, fexp2_pkg::COEF_W'($urandom));
      write_coef(CSR_SPARE, fexp2_pkg::COEF_W'($urandom));
      write_coef(fexp2_pkg::CSR_LINEAR, fexp2_pkg::COEF_W'($urandom));
      write_coef(fexp2_pkg::CSR_SQUARE, fexp2_pkg::COEF_W'($urandom));
      end_writes();
      queue_random(90);
      wait_drained();
      queue_random(90);
      wait_drained();

      // mixed: linear at full scale, cube off
      write_coef(fexp2_pkg::CSR_LINEAR, 24'hFFFFFF);
      write_coef(fexp2_pkg::CSR_SQUARE, fexp2_pkg::COEF_W'($urandom));
      write_coef(fexp2_pkg::CSR_CUBE, 24'h000000);
      end_writes();
      queue_random(150);
      wait_drained();

      // back to the reset values, back-to-back words with no gaps
      write_coef(fexp2_pkg::CSR_LINEAR, fexp2_pkg::LINEAR_RST);
      write_coef(fexp2_pkg::CSR_SQUARE, fexp2_pkg::SQUARE_RST);
      write_coef(fexp2_pkg::CSR_CUBE, fexp2_pkg::CUBE_RST);
      end_writes();
      sender_bursts_on = 1'b0;
      queue_random(230);
      wait_drained();

      repeat (8) @(posedge clock);
      mismatch_count += expected_powers.size();
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+design
design/fexp2_pkg.sv
design/fexp2_csr.sv
design/fexp2_horner.sv
design/fexp2_pack.sv
design/fast_exp2_approx.sv
sim/fast_exp2_approx_tb.sv
